// ----- rtl/core/ngps_pkg.sv -----
// Shared constants and codes for the nearest grid point search core.
`timescale 1ns / 1ps

package ngps_pkg;

    // Default table depths and coordinate width
    localparam int NGPS_MAX_LON_POINTS = 256;
    localparam int NGPS_MAX_LAT_POINTS = 256;
    localparam int NGPS_COORD_WIDTH    = 18;

    // Configuration port
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LON_POINTS = 1'd0,
        REG_LAT_POINTS = 1'd1
    } cfg_reg_t;

    // Item opcodes
    typedef enum logic [1:0] {
        MODE_WR_LON = 2'd0,
        MODE_WR_LAT = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

endpackage

// ----- rtl/core/nearest_grid_point_search_core.sv -----
// Top level of the nearest grid point search core.
`timescale 1ns / 1ps

// Nearest grid point search. Two coordinate tables (longitude, latitude)
// live in two rows of cells, one cell per table entry. Mode 0 / mode 1 items
// write one entry; they make no result. A mode 2 item (query) starts a token
// at the head of both rows; each cycle it moves one cell to the right, and
// each cell within the configured point count replaces the carried best
// match when its absolute distance to the query is strictly smaller, so the
// lowest index wins ties. m_valid rises once the token has left the end of
// the longer row and both results are captured, and the input becomes ready
// again in the same cycle, so the time a query holds the input is set by the
// length of the longer row, whatever the point counts are. One query is in
// flight at a time; the input is not ready while it walks the rows. The
// result sits in an output register, so the next item is taken while it
// waits for m_ready; if the previous result still waits there when a query
// finishes, the input stays off until the output register frees up. Point
// counts of 0 act as 1, counts above the depth scan the whole row, and
// writes to an index past the depth are dropped. Querying an entry that was
// never written returns an unspecified coordinate. The user must write point
// counts through the cfg port only while the core is idle; the core does
// not enforce this.
module nearest_grid_point_search_core
    import ngps_pkg::*;
#(
    parameter int MAX_LON_POINTS = NGPS_MAX_LON_POINTS,
    parameter int MAX_LAT_POINTS = NGPS_MAX_LAT_POINTS,
    parameter int COORD_WIDTH    = NGPS_COORD_WIDTH,
    parameter int LON_POS_W      = $clog2(MAX_LON_POINTS),
    parameter int LAT_POS_W      = $clog2(MAX_LAT_POINTS),
    parameter int INDEX_WIDTH    = (LON_POS_W > LAT_POS_W) ? LON_POS_W : LAT_POS_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [INDEX_WIDTH-1:0]        s_entry_index,
    input  logic signed [COORD_WIDTH-1:0] s_entry_value,
    input  logic signed [COORD_WIDTH-1:0] s_query_lon,
    input  logic signed [COORD_WIDTH-1:0] s_query_lat,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_nearest_lon,
    output logic signed [COORD_WIDTH-1:0] m_nearest_lat,
    output logic [LON_POS_W-1:0]          m_lon_position,
    output logic [LAT_POS_W-1:0]          m_lat_position
);

    // control state
    logic                  busy_reg;       // query walking the rows
    logic                  start_reg;      // token injection pulse
    logic                  lon_done_reg;   // longitude result captured
    logic                  lat_done_reg;   // latitude result captured
    logic                  m_valid_reg;
    logic [CFG_DATA_W-1:0] lon_count_reg;
    logic [CFG_DATA_W-1:0] lat_count_reg;

    // payload
    logic signed [COORD_WIDTH-1:0] q_lon_reg;
    logic signed [COORD_WIDTH-1:0] q_lat_reg;
    logic signed [COORD_WIDTH-1:0] lon_val_reg;
    logic signed [COORD_WIDTH-1:0] lat_val_reg;
    logic [LON_POS_W-1:0]          lon_pos_reg;
    logic [LAT_POS_W-1:0]          lat_pos_reg;
    logic signed [COORD_WIDTH-1:0] m_lon_reg;
    logic signed [COORD_WIDTH-1:0] m_lat_reg;
    logic [LON_POS_W-1:0]          m_lon_pos_reg;
    logic [LAT_POS_W-1:0]          m_lat_pos_reg;

    logic                          accept;
    logic                          query_accept;
    logic                          lon_wr;
    logic                          lat_wr;
    logic                          xfer;
    logic                          lon_tail_valid;
    logic                          lat_tail_valid;
    logic [LON_POS_W-1:0]          lon_tail_pos;
    logic [LAT_POS_W-1:0]          lat_tail_pos;
    logic signed [COORD_WIDTH-1:0] lon_tail_val;
    logic signed [COORD_WIDTH-1:0] lat_tail_val;

    assign s_ready      = !busy_reg;
    assign accept       = s_valid && s_ready;
    assign query_accept = accept && (s_mode == MODE_QUERY);
    assign lon_wr       = accept && (s_mode == MODE_WR_LON);
    assign lat_wr       = accept && (s_mode == MODE_WR_LAT);
    // both axes finished and the output register is free
    assign xfer         = lon_done_reg && lat_done_reg && (!m_valid_reg || m_ready);

    ngps_chain #(
        .DEPTH       (MAX_LON_POINTS),
        .INDEX_WIDTH (INDEX_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .POS_W       (LON_POS_W)
    ) u_lon_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (lon_wr),
        .wr_index (s_entry_index),
        .wr_value (s_entry_value),
        .start    (start_reg),
        .query    (q_lon_reg),
        .count    (lon_count_reg),
        .done     (lon_tail_valid),
        .best_pos (lon_tail_pos),
        .best_val (lon_tail_val)
    );

    ngps_chain #(
        .DEPTH       (MAX_LAT_POINTS),
        .INDEX_WIDTH (INDEX_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .POS_W       (LAT_POS_W)
    ) u_lat_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (lat_wr),
        .wr_index (s_entry_index),
        .wr_value (s_entry_value),
        .start    (start_reg),
        .query    (q_lat_reg),
        .count    (lat_count_reg),
        .done     (lat_tail_valid),
        .best_pos (lat_tail_pos),
        .best_val (lat_tail_val)
    );

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            lon_done_reg  <= 1'b0;
            lat_done_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            lon_count_reg <= CFG_DATA_W'(1);
            lat_count_reg <= CFG_DATA_W'(1);
        end else begin
            start_reg <= query_accept;

            if (query_accept) begin
                busy_reg <= 1'b1;
            end

            if (lon_tail_valid) begin
                lon_done_reg <= 1'b1;
            end
            if (lat_tail_valid) begin
                lat_done_reg <= 1'b1;
            end

            if (xfer) begin
                lon_done_reg <= 1'b0;
                lat_done_reg <= 1'b0;
                busy_reg     <= 1'b0;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LON_POINTS: begin
                        lon_count_reg <= cfg_wdata;
                    end
                    REG_LAT_POINTS: begin
                        lat_count_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // query coordinates held while the token walks
    always_ff @(posedge aclk) begin
        if (query_accept) begin
            q_lon_reg <= s_query_lon;
            q_lat_reg <= s_query_lat;
        end
    end

    // per-axis capture: rows of different length finish at different times
    always_ff @(posedge aclk) begin
        if (lon_tail_valid) begin
            lon_val_reg <= lon_tail_val;
            lon_pos_reg <= lon_tail_pos;
        end
        if (lat_tail_valid) begin
            lat_val_reg <= lat_tail_val;
            lat_pos_reg <= lat_tail_pos;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (xfer) begin
            m_lon_reg     <= lon_val_reg;
            m_lat_reg     <= lat_val_reg;
            m_lon_pos_reg <= lon_pos_reg;
            m_lat_pos_reg <= lat_pos_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_nearest_lon  = m_lon_reg;
    assign m_nearest_lat  = m_lat_reg;
    assign m_lon_position = m_lon_pos_reg;
    assign m_lat_position = m_lat_pos_reg;

endmodule

// ----- rtl/core/ngps_cell.sv -----
// One search cell: holds a table entry and updates the passing best match.
`timescale 1ns / 1ps

module ngps_cell
    import ngps_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int POS_W       = 8,
    parameter int INDEX_WIDTH = 8,
    parameter int COORD_WIDTH = NGPS_COORD_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // entry write
    input  logic                          wr_en,
    input  logic [INDEX_WIDTH-1:0]        wr_index,
    input  logic signed [COORD_WIDTH-1:0] wr_value,
    // broadcast query
    input  logic signed [COORD_WIDTH-1:0] query,
    input  logic [CFG_DATA_W-1:0]         count,
    // from left neighbor
    input  logic                          in_valid,
    input  logic [COORD_WIDTH:0]          in_diff,
    input  logic [POS_W-1:0]              in_pos,
    input  logic signed [COORD_WIDTH-1:0] in_val,
    // to right neighbor
    output logic                          out_valid,
    output logic [COORD_WIDTH:0]          out_diff,
    output logic [POS_W-1:0]              out_pos,
    output logic signed [COORD_WIDTH-1:0] out_val
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int CMP_W = ((POS_W > CFG_DATA_W) ? POS_W : CFG_DATA_W) + 1;

    logic signed [COORD_WIDTH-1:0] entry_reg;
    logic                          valid_reg;
    logic [DW-1:0]                 diff_reg;
    logic [POS_W-1:0]              pos_reg;
    logic signed [COORD_WIDTH-1:0] val_reg;

    logic [DW-1:0] delta;
    logic [DW-1:0] abs_delta;
    logic          active;
    logic          take;

    always_comb begin
        delta     = {query[COORD_WIDTH-1], query} - {entry_reg[COORD_WIDTH-1], entry_reg};
        abs_delta = delta[DW-1] ? (~delta + 1'b1) : delta;
        // cell 0 always counts: a zero count acts as one
        active    = (IDX == 0) || (CMP_W'(IDX) < CMP_W'(count));
        // strict compare keeps the lowest index on ties
        take      = (IDX == 0) || (active && (abs_delta < in_diff));
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_index == INDEX_WIDTH'(IDX))) begin
            entry_reg <= wr_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            diff_reg <= abs_delta;
            pos_reg  <= POS_W'(IDX);
            val_reg  <= entry_reg;
        end else begin
            diff_reg <= in_diff;
            pos_reg  <= in_pos;
            val_reg  <= in_val;
        end
    end

    assign out_valid = valid_reg;
    assign out_diff  = diff_reg;
    assign out_pos   = pos_reg;
    assign out_val   = val_reg;

endmodule

// ----- rtl/core/ngps_chain.sv -----
// Row of search cells for one axis; the query token walks one cell per cycle.
`timescale 1ns / 1ps

module ngps_chain
    import ngps_pkg::*;
#(
    parameter int DEPTH       = NGPS_MAX_LON_POINTS,
    parameter int INDEX_WIDTH = 8,
    parameter int COORD_WIDTH = NGPS_COORD_WIDTH,
    parameter int POS_W       = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [INDEX_WIDTH-1:0]        wr_index,
    input  logic signed [COORD_WIDTH-1:0] wr_value,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] query,
    input  logic [CFG_DATA_W-1:0]         count,
    output logic                          done,
    output logic [POS_W-1:0]              best_pos,
    output logic signed [COORD_WIDTH-1:0] best_val
);

    logic                          valid_link [0:DEPTH];
    logic [COORD_WIDTH:0]          diff_link  [0:DEPTH];
    logic [POS_W-1:0]              pos_link   [0:DEPTH];
    logic signed [COORD_WIDTH-1:0] val_link   [0:DEPTH];

    // head of the row: cell 0 seeds the best match itself
    assign valid_link[0] = start;
    assign diff_link[0]  = '0;
    assign pos_link[0]   = '0;
    assign val_link[0]   = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ngps_cell #(
            .IDX         (i),
            .POS_W       (POS_W),
            .INDEX_WIDTH (INDEX_WIDTH),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .wr_en     (wr_en),
            .wr_index  (wr_index),
            .wr_value  (wr_value),
            .query     (query),
            .count     (count),
            .in_valid  (valid_link[i]),
            .in_diff   (diff_link[i]),
            .in_pos    (pos_link[i]),
            .in_val    (val_link[i]),
            .out_valid (valid_link[i+1]),
            .out_diff  (diff_link[i+1]),
            .out_pos   (pos_link[i+1]),
            .out_val   (val_link[i+1])
        );
    end

    assign done     = valid_link[DEPTH];
    assign best_pos = pos_link[DEPTH];
    assign best_val = val_link[DEPTH];

endmodule
